// ----- rtl/ffba_pkg.sv -----
// Package: constants and word types of the first-fit block allocator.
package ffba_pkg;

  localparam int unsigned BufBytes    = 4096;
  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned MaxRecords  = 64;

  localparam int unsigned SlotW  = $clog2(MaxRecords);
  localparam int unsigned LinkW  = SlotW + 1;
  localparam int unsigned AddrW  = 12;
  localparam int unsigned SizeW  = 13;
  localparam int unsigned CountW = $clog2(MaxRecords + 1);
  localparam int unsigned CalcW  = 16;

  // link code with the top bit set means no record follows
  localparam logic [LinkW-1:0] LinkNone = LinkW'(MaxRecords);

  localparam logic [1:0] ReqAlloc   = 2'd0;
  localparam logic [1:0] ReqFree    = 2'd1;
  localparam logic [1:0] ReqRealloc = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StBadAddr = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [SizeW-1:0] req_size;
    logic [AddrW-1:0] req_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] result_addr;
    logic [SizeW-1:0] bytes_free;
  } rsp_t;

  // one record of the table memory
  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [SizeW-1:0] length;
    logic [LinkW-1:0] next;
  } rec_t;

  typedef struct packed {
    logic             rd_en;
    logic [SlotW-1:0] rd_slot;
    logic             wr_en;
    logic [SlotW-1:0] wr_slot;
    rec_t             wr_rec;
  } mem_req_t;

endpackage

// ----- rtl/first_fit_block_allocator.sv -----
// First-fit block allocator: map of a 4096-byte buffer kept as a linked record table.
// Operation: an unknown request goes straight to the result word; otherwise an address walk
// (free, reallocate) and a first-fit walk (allocate, reallocate) of up to 64 records each, then
// the steps that link in the new record and unlink the old one.
// Throughput: one request at a time; the next is taken in the cycle after the result word leaves.
// Reset: asynchronous, active low; empties the list, free count to 4088, no table sweep.
module first_fit_block_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ffba_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ffba_pkg::rsp_t out_data_o
);

  ffba_pkg::mem_req_t mreq;
  ffba_pkg::rec_t     rd_rec;

  ffba_rec_mem u_mem (
    .clk_i    (clk_i),
    .mreq_i   (mreq),
    .rd_rec_o (rd_rec)
  );

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mreq_o      (mreq),
    .rd_rec_i    (rd_rec)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("request taken while word pending");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ffba_pkg::StOk) |-> out_data_o.result_addr == '0)
    else $error("failed request returned an address");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mreq.rd_en && mreq.wr_en)) else $error("table read and write in one cycle");

endmodule

// ----- rtl/ffba_rec_mem.sv -----
// Record table: synchronous memory, one read and one write port, registered read data.
module ffba_rec_mem (
  input  logic               clk_i,
  input  ffba_pkg::mem_req_t mreq_i,
  output ffba_pkg::rec_t     rd_rec_o
);

  ffba_pkg::rec_t mem_q [ffba_pkg::MaxRecords];

  always_ff @(posedge clk_i) begin
    if (mreq_i.wr_en) begin
      mem_q[mreq_i.wr_slot] <= mreq_i.wr_rec;
    end
    if (mreq_i.rd_en) begin
      rd_rec_o <= mem_q[mreq_i.rd_slot];
    end
  end

endmodule

// ----- rtl/ffba_ctrl.sv -----
// Sequencer: walks the record list, links in and unlinks records.
module ffba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ffba_pkg::req_t     in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ffba_pkg::rsp_t     out_data_o,
  output ffba_pkg::mem_req_t mreq_o,
  input  ffba_pkg::rec_t     rd_rec_i
);

  localparam int unsigned SW = ffba_pkg::SlotW;
  localparam int unsigned LW = ffba_pkg::LinkW;
  localparam int unsigned CW = ffba_pkg::CalcW;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SFind  = 4'd1;  // walk looking for req_addr
  localparam logic [3:0] SFindW = 4'd2;
  localparam logic [3:0] SFit   = 4'd3;  // first-fit walk
  localparam logic [3:0] SFitW  = 4'd4;
  localparam logic [3:0] SAlloc = 4'd5;
  localparam logic [3:0] SUnRd  = 4'd6;  // read victim record (at root) or its predecessor
  localparam logic [3:0] SUnRdW = 4'd7;
  localparam logic [3:0] SUnPrv = 4'd8;  // read predecessor for rewrite
  localparam logic [3:0] SUnPrW = 4'd9;
  localparam logic [3:0] SUnWr  = 4'd10;
  localparam logic [3:0] SOut   = 4'd11;
  localparam logic [3:0] SUnVic = 4'd12; // victim record arrives
  localparam logic [3:0] SUnLnk = 4'd13; // relink predecessor past victim

  logic [3:0] state_q, state_d;
  ffba_pkg::req_t req_q, req_d;
  logic [LW-1:0] cur_q, cur_d;       // current slot, LinkNone marks root
  logic [CW-1:0] cur_end_q, cur_end_d; // start+header+length of current
  logic [LW-1:0] nxt_q, nxt_d;       // link out of current
  logic [LW-1:0] prev_q, prev_d;     // predecessor found by the address walk
  logic [LW-1:0] root_q, root_d;
  logic [ffba_pkg::CountW-1:0] count_q, count_d;
  logic [ffba_pkg::SizeW-1:0] avail_q, avail_d;
  logic [ffba_pkg::MaxRecords-1:0] used_q, used_d;
  logic [SW-1:0] free_slot;
  logic [CW-1:0] victim_bytes_q, victim_bytes_d;
  logic [LW-1:0] victim_next_q, victim_next_d;
  logic [ffba_pkg::AddrW-1:0] new_addr_q, new_addr_d;
  logic ovalid_q, ovalid_d;
  ffba_pkg::rsp_t odata_q, odata_d;
  ffba_pkg::mem_req_t mreq;
  logic [CW-1:0] rec_end, need_end;

  assign in_stall_o  = (state_q != SIdle) || ovalid_q;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign mreq_o      = mreq;

  always_comb begin
    free_slot = '0;
    for (int i = ffba_pkg::MaxRecords - 1; i >= 0; i--) begin
      if (!used_q[i]) free_slot = SW'(i);
    end
  end

  assign rec_end  = CW'(rd_rec_i.start) + CW'(ffba_pkg::HeaderBytes) + CW'(rd_rec_i.length);
  assign need_end = cur_end_q + CW'(req_q.req_size) + CW'(ffba_pkg::HeaderBytes);

  always_comb begin
    state_d = state_q; req_d = req_q; cur_d = cur_q; cur_end_d = cur_end_q;
    nxt_d = nxt_q; prev_d = prev_q; root_d = root_q; count_d = count_q;
    avail_d = avail_q; used_d = used_q; victim_bytes_d = victim_bytes_q;
    victim_next_d = victim_next_q; new_addr_d = new_addr_q;
    ovalid_d = ovalid_q; odata_d = odata_q;
    mreq = '0;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    case (state_q)
      SIdle: begin
        if (in_valid_i && !in_stall_o) begin
          req_d = in_data_i;
          cur_d = ffba_pkg::LinkNone; nxt_d = root_q;
          cur_end_d = CW'(ffba_pkg::HeaderBytes);
          new_addr_d = '0;
          if (in_data_i.req_type == ffba_pkg::ReqAlloc) state_d = SFit;
          else if (in_data_i.req_type == ffba_pkg::ReqFree ||
                   in_data_i.req_type == ffba_pkg::ReqRealloc) state_d = SFind;
          else begin
            odata_d = '{ffba_pkg::StBadAddr, '0, avail_q};
            state_d = SOut;
          end
        end
      end
      SFind: begin
        if (nxt_q[LW-1]) begin
          odata_d = '{ffba_pkg::StBadAddr, '0, avail_q};
          state_d = SOut;
        end else begin
          mreq.rd_en = 1'b1; mreq.rd_slot = nxt_q[SW-1:0];
          state_d = SFindW;
        end
      end
      SFindW: begin
        if (ffba_pkg::AddrW'(CW'(rd_rec_i.start) + CW'(ffba_pkg::HeaderBytes)) ==
            req_q.req_addr &&
            (CW'(rd_rec_i.start) + CW'(ffba_pkg::HeaderBytes)) < CW'(ffba_pkg::BufBytes)) begin
          prev_d = cur_q;
          if (req_q.req_type == ffba_pkg::ReqFree) begin
            state_d = SUnRd;
          end else begin
            cur_d = ffba_pkg::LinkNone; nxt_d = root_q;
            cur_end_d = CW'(ffba_pkg::HeaderBytes);
            state_d = SFit;
          end
        end else begin
          cur_d = nxt_q; nxt_d = rd_rec_i.next;
          state_d = SFind;
        end
      end
      SFit: begin
        if (nxt_q[LW-1]) begin
          if (need_end < CW'(ffba_pkg::BufBytes)) state_d = SAlloc;
          else begin
            odata_d = '{ffba_pkg::StNoSpace, '0, avail_q};
            state_d = SOut;
          end
        end else begin
          mreq.rd_en = 1'b1; mreq.rd_slot = nxt_q[SW-1:0];
          state_d = SFitW;
        end
      end
      SFitW: begin
        if (need_end < CW'(rd_rec_i.start)) state_d = SAlloc;
        else begin
          cur_d = nxt_q; nxt_d = rd_rec_i.next; cur_end_d = rec_end;
          state_d = SFit;
        end
      end
      SAlloc: begin
        if (count_q >= ffba_pkg::CountW'(ffba_pkg::MaxRecords)) begin
          odata_d = '{ffba_pkg::StFull, '0, avail_q};
          state_d = SOut;
        end else begin
          // write new record, then relink current (root in register)
          mreq.wr_en = 1'b1; mreq.wr_slot = free_slot;
          mreq.wr_rec = '{ffba_pkg::AddrW'(cur_end_q), req_q.req_size, nxt_q};
          used_d[free_slot] = 1'b1;
          count_d = count_q + 1'b1;
          avail_d = avail_q - ffba_pkg::SizeW'(CW'(req_q.req_size) +
                                               CW'(ffba_pkg::HeaderBytes));
          new_addr_d = ffba_pkg::AddrW'(cur_end_q + CW'(ffba_pkg::HeaderBytes));
          if (cur_q[LW-1]) begin
            root_d = LW'(free_slot);
          end else begin
            // rewrite current record's link: read it back first
            victim_next_d = LW'(free_slot);
          end
          if (req_q.req_type == ffba_pkg::ReqRealloc && prev_q == cur_q &&
              !cur_q[LW-1]) begin
            prev_d = LW'(free_slot);
          end else if (req_q.req_type == ffba_pkg::ReqRealloc && prev_q[LW-1] &&
                       cur_q[LW-1]) begin
            prev_d = LW'(free_slot);
          end
          state_d = cur_q[LW-1] ? SUnRd : SUnPrv;
          nxt_d = ffba_pkg::LinkNone; // link out of current cleared
        end
      end
      SUnPrv: begin
        mreq.rd_en = 1'b1; mreq.rd_slot = cur_q[SW-1:0];
        state_d = SUnPrW;
      end
      SUnPrW: begin
        mreq.wr_en = 1'b1; mreq.wr_slot = cur_q[SW-1:0];
        mreq.wr_rec = '{rd_rec_i.start, rd_rec_i.length, victim_next_q};
        state_d = SUnRd;
      end
      SUnRd: begin
        if (req_q.req_type == ffba_pkg::ReqAlloc) begin
          odata_d = '{ffba_pkg::StOk, new_addr_q, avail_q};
          state_d = SOut;
        end else begin
          // victim is link out of prev
          if (prev_q[LW-1]) begin
            mreq.rd_en = 1'b1; mreq.rd_slot = root_q[SW-1:0];
            cur_d = root_q;
          end else begin
            mreq.rd_en = 1'b1; mreq.rd_slot = prev_q[SW-1:0];
            cur_d = prev_q;
          end
          state_d = SUnRdW;
        end
      end
      SUnRdW: begin
        if (prev_q[LW-1]) begin
          victim_bytes_d = CW'(rd_rec_i.length) + CW'(ffba_pkg::HeaderBytes);
          used_d[cur_q[SW-1:0]] = 1'b0;
          root_d = rd_rec_i.next;
          state_d = SUnWr;
        end else begin
          // got prev record; read victim next
          victim_next_d = rd_rec_i.next;
          mreq.rd_en = 1'b1; mreq.rd_slot = rd_rec_i.next[SW-1:0];
          cur_d = rd_rec_i.next;
          state_d = SUnVic;
        end
      end
      SUnVic: begin
        // victim record in rd_rec_i, prev slot in prev_q
        victim_bytes_d = CW'(rd_rec_i.length) + CW'(ffba_pkg::HeaderBytes);
        used_d[cur_q[SW-1:0]] = 1'b0;
        victim_next_d = rd_rec_i.next;
        mreq.rd_en = 1'b1; mreq.rd_slot = prev_q[SW-1:0];
        state_d = SUnLnk;
      end
      SUnLnk: begin
        mreq.wr_en = 1'b1; mreq.wr_slot = prev_q[SW-1:0];
        mreq.wr_rec = '{rd_rec_i.start, rd_rec_i.length, victim_next_q};
        state_d = SUnWr;
      end
      SUnWr: begin
        avail_d = avail_q + ffba_pkg::SizeW'(victim_bytes_q);
        count_d = count_q - 1'b1;
        odata_d = '{ffba_pkg::StOk, new_addr_q,
                    avail_q + ffba_pkg::SizeW'(victim_bytes_q)};
        state_d = SOut;
      end
      SOut: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      root_q <= ffba_pkg::LinkNone;
      count_q <= '0;
      avail_q <= ffba_pkg::SizeW'(ffba_pkg::BufBytes - ffba_pkg::HeaderBytes);
      used_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; root_q <= root_d; count_q <= count_d;
      avail_q <= avail_d; used_q <= used_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; cur_q <= cur_d; cur_end_q <= cur_end_d; nxt_q <= nxt_d;
    prev_q <= prev_d; victim_bytes_q <= victim_bytes_d;
    victim_next_q <= victim_next_d; new_addr_q <= new_addr_d; odata_q <= odata_d;
  end

endmodule
